// ----- sv/sip_pkg.sv -----
// ----------------------------------------------------------------------------
// sip_pkg
// Shared widths and payload types for the segment intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sip_pkg;

    localparam int COORD_BITS = 12;
    localparam int DIFF_W     = COORD_BITS + 1;        // signed coordinate difference
    localparam int PROD_W     = 2 * COORD_BITS;        // unsigned coordinate product
    localparam int SPROD_W    = 2 * COORD_BITS + 2;    // signed difference product
    localparam int CA_W       = 2 * COORD_BITS + 1;    // signed line constant
    localparam int NUM_W      = 3 * COORD_BITS + 2;    // signed numerator
    localparam int MAG_W      = 3 * COORD_BITS + 2;    // unsigned magnitudes in divider

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t ax0;
        coord_t ay0;
        coord_t ax1;
        coord_t ay1;
        coord_t bx0;
        coord_t by0;
        coord_t bx1;
        coord_t by1;
    } seg_pair_t;

    // intersection of the two bounding boxes
    typedef struct packed {
        coord_t lo_x;
        coord_t hi_x;
        coord_t lo_y;
        coord_t hi_y;
    } box_t;

    typedef struct packed {
        logic [MAG_W-1:0] num_x;
        logic [MAG_W-1:0] num_y;
        logic [MAG_W-1:0] den;
        logic             neg_x;
        logic             neg_y;
        logic             zero;
        box_t             box;
    } div_in_t;

    typedef struct packed {
        coord_t qx;
        coord_t qy;
        logic   neg_x;
        logic   neg_y;
        logic   miss;
        box_t   box;
    } div_out_t;

    function automatic coord_t cmin(input coord_t a, input coord_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic coord_t cmax(input coord_t a, input coord_t b);
        return (a < b) ? b : a;
    endfunction

endpackage

`default_nettype wire

// ----- sv/sip_front.sv -----
// ----------------------------------------------------------------------------
// sip_front
// Four pipeline stages: differences and products, determinant and line
// constants, numerator products, numerators folded to sign and magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module sip_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire sip_pkg::seg_pair_t in_data,
    output logic                    out_valid,
    output sip_pkg::div_in_t        out_data
);
    import sip_pkg::*;

    // stage 1
    logic                      v1_reg;
    logic signed [DIFF_W-1:0]  dxa_reg, dya_reg, dxb_reg, dyb_reg;
    logic [PROD_W-1:0]         pa1_reg, pa2_reg, pb1_reg, pb2_reg;
    logic signed [SPROD_W-1:0] pd1_reg, pd2_reg;
    box_t                      box1_reg;
    // stage 2
    logic                      v2_reg;
    logic signed [DIFF_W-1:0]  dxa2_reg, dya2_reg, dxb2_reg, dyb2_reg;
    logic signed [SPROD_W-1:0] det2_reg;
    logic signed [CA_W-1:0]    ca_reg, cb_reg;
    box_t                      box2_reg;
    // stage 3
    logic                      v3_reg;
    logic signed [NUM_W-1:0]   mxa_reg, mxb_reg, mya_reg, myb_reg;
    logic signed [SPROD_W-1:0] det3_reg;
    box_t                      box3_reg;
    // stage 4
    logic                      v4_reg;
    div_in_t                   d4_reg;

    logic signed [DIFF_W-1:0]  dxa_next, dya_next, dxb_next, dyb_next;
    logic signed [NUM_W-1:0]   numx, numy;
    box_t                      box_next;

    always_comb begin
        dxa_next = signed'({1'b0, in_data.ax0}) - signed'({1'b0, in_data.ax1});
        dya_next = signed'({1'b0, in_data.ay0}) - signed'({1'b0, in_data.ay1});
        dxb_next = signed'({1'b0, in_data.bx0}) - signed'({1'b0, in_data.bx1});
        dyb_next = signed'({1'b0, in_data.by0}) - signed'({1'b0, in_data.by1});
        box_next.lo_x = cmax(cmin(in_data.ax0, in_data.ax1), cmin(in_data.bx0, in_data.bx1));
        box_next.hi_x = cmin(cmax(in_data.ax0, in_data.ax1), cmax(in_data.bx0, in_data.bx1));
        box_next.lo_y = cmax(cmin(in_data.ay0, in_data.ay1), cmin(in_data.by0, in_data.by1));
        box_next.hi_y = cmin(cmax(in_data.ay0, in_data.ay1), cmax(in_data.by0, in_data.by1));
        numx = mxa_reg - mxb_reg;
        numy = mya_reg - myb_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1
            dxa_reg  <= dxa_next;
            dya_reg  <= dya_next;
            dxb_reg  <= dxb_next;
            dyb_reg  <= dyb_next;
            pa1_reg  <= PROD_W'(in_data.ax0) * PROD_W'(in_data.ay1);
            pa2_reg  <= PROD_W'(in_data.ay0) * PROD_W'(in_data.ax1);
            pb1_reg  <= PROD_W'(in_data.bx0) * PROD_W'(in_data.by1);
            pb2_reg  <= PROD_W'(in_data.by0) * PROD_W'(in_data.bx1);
            pd1_reg  <= SPROD_W'(dxa_next) * SPROD_W'(dyb_next);
            pd2_reg  <= SPROD_W'(dya_next) * SPROD_W'(dxb_next);
            box1_reg <= box_next;
            // stage 2
            dxa2_reg <= dxa_reg;
            dya2_reg <= dya_reg;
            dxb2_reg <= dxb_reg;
            dyb2_reg <= dyb_reg;
            det2_reg <= pd1_reg - pd2_reg;
            ca_reg   <= signed'({1'b0, pa1_reg}) - signed'({1'b0, pa2_reg});
            cb_reg   <= signed'({1'b0, pb1_reg}) - signed'({1'b0, pb2_reg});
            box2_reg <= box1_reg;
            // stage 3
            mxa_reg  <= NUM_W'(ca_reg) * NUM_W'(dxb2_reg);
            mxb_reg  <= NUM_W'(dxa2_reg) * NUM_W'(cb_reg);
            mya_reg  <= NUM_W'(ca_reg) * NUM_W'(dyb2_reg);
            myb_reg  <= NUM_W'(dya2_reg) * NUM_W'(cb_reg);
            det3_reg <= det2_reg;
            box3_reg <= box2_reg;
            // stage 4: sign and magnitude
            d4_reg.num_x <= MAG_W'(numx[NUM_W-1] ? -numx : numx);
            d4_reg.num_y <= MAG_W'(numy[NUM_W-1] ? -numy : numy);
            d4_reg.den   <= MAG_W'(det3_reg[SPROD_W-1] ? -det3_reg : det3_reg);
            d4_reg.neg_x <= (numx[NUM_W-1] != det3_reg[SPROD_W-1]) && (numx != '0);
            d4_reg.neg_y <= (numy[NUM_W-1] != det3_reg[SPROD_W-1]) && (numy != '0);
            d4_reg.zero  <= (det3_reg == '0);
            d4_reg.box   <= box3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = d4_reg;

endmodule

`default_nettype wire

// ----- sv/sip_div.sv -----
// ----------------------------------------------------------------------------
// sip_div
// Pipelined restoring divider: a range check stage, then one quotient bit
// per stage for x and y side by side.
// ----------------------------------------------------------------------------
`default_nettype none

module sip_div (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire sip_pkg::div_in_t in_data,
    output logic                  out_valid,
    output sip_pkg::div_out_t     out_data
);
    import sip_pkg::*;

    typedef struct packed {
        logic [MAG_W-1:0] rx;
        logic [MAG_W-1:0] ry;
        logic [MAG_W-1:0] den;
        coord_t           qx;
        coord_t           qy;
        logic             neg_x;
        logic             neg_y;
        logic             miss;
        box_t             box;
    } dstage_t;

    dstage_t st_reg [COORD_BITS+1];
    logic    v_reg  [COORD_BITS+1];

    logic [MAG_W-1:0] den_top;

    // quotient beyond the coordinate range can never land in a box
    assign den_top = in_data.den << COORD_BITS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0].rx    <= in_data.num_x;
            st_reg[0].ry    <= in_data.num_y;
            st_reg[0].den   <= in_data.den;
            st_reg[0].qx    <= '0;
            st_reg[0].qy    <= '0;
            st_reg[0].neg_x <= in_data.neg_x;
            st_reg[0].neg_y <= in_data.neg_y;
            st_reg[0].miss  <= in_data.zero || (in_data.num_x >= den_top)
                               || (in_data.num_y >= den_top);
            st_reg[0].box   <= in_data.box;
        end
    end

    for (genvar k = 0; k < COORD_BITS; k++) begin : g_bit
        localparam int B = COORD_BITS - 1 - k;
        logic [MAG_W-1:0] dsh;
        logic             gex, gey;
        dstage_t          nxt;

        always_comb begin
            dsh = st_reg[k].den << B;
            gex = st_reg[k].rx >= dsh;
            gey = st_reg[k].ry >= dsh;
            nxt = st_reg[k];
            if (gex) begin
                nxt.rx = st_reg[k].rx - dsh;
                nxt.qx = st_reg[k].qx | (coord_t'(1) << B);
            end
            if (gey) begin
                nxt.ry = st_reg[k].ry - dsh;
                nxt.qy = st_reg[k].qy | (coord_t'(1) << B);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[k+1] <= nxt;
            end
        end
    end

    assign out_valid      = v_reg[COORD_BITS];
    assign out_data.qx    = st_reg[COORD_BITS].qx;
    assign out_data.qy    = st_reg[COORD_BITS].qy;
    assign out_data.neg_x = st_reg[COORD_BITS].neg_x;
    assign out_data.neg_y = st_reg[COORD_BITS].neg_y;
    assign out_data.miss  = st_reg[COORD_BITS].miss;
    assign out_data.box   = st_reg[COORD_BITS].box;

endmodule

`default_nettype wire

// ----- sv/segment_intersection_point.sv -----
// ----------------------------------------------------------------------------
// segment_intersection_point
// Integer intersection point of two pixel segments with box test.
// ----------------------------------------------------------------------------
// Input channel s_*: one beat carries both endpoints of segments a and b.
// Result channel m_*: one beat per input beat, in order, with m_hit and the
// truncated point; cross_x and cross_y are zero on a miss.
// From input beat to result beat the path runs through four arithmetic
// stages (products, determinant, numerator products, sign/magnitude), one
// range check stage, one stage per quotient bit of the divider (12 at the
// default coordinate width) and the output register.
// Throughput is one beat per cycle while the output is not stalled; the divider pipeline sets the depth.
// The whole pipeline advances together: when the receiver holds m_ready low
// with a result waiting, every stage holds and s_ready drops, so nothing is
// lost or repeated. Bubbles move on while the output is empty.
// Reset (aresetn low, synchronous) empties all stages; s_ready is high
// right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_point (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire sip_pkg::coord_t    s_a_start_x,
    input  wire sip_pkg::coord_t    s_a_start_y,
    input  wire sip_pkg::coord_t    s_a_end_x,
    input  wire sip_pkg::coord_t    s_a_end_y,
    input  wire sip_pkg::coord_t    s_b_start_x,
    input  wire sip_pkg::coord_t    s_b_start_y,
    input  wire sip_pkg::coord_t    s_b_end_x,
    input  wire sip_pkg::coord_t    s_b_end_y,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_hit,
    output sip_pkg::coord_t         m_cross_x,
    output sip_pkg::coord_t         m_cross_y
);
    import sip_pkg::*;

    logic      en;
    seg_pair_t pair;
    logic      f_valid, d_valid;
    div_in_t   f_data;
    div_out_t  d_data;

    logic      m_valid_reg, m_hit_reg, hit_next;
    coord_t    m_x_reg, m_y_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    assign pair.ax0 = s_a_start_x;
    assign pair.ay0 = s_a_start_y;
    assign pair.ax1 = s_a_end_x;
    assign pair.ay1 = s_a_end_y;
    assign pair.bx0 = s_b_start_x;
    assign pair.by0 = s_b_start_y;
    assign pair.bx1 = s_b_end_x;
    assign pair.by1 = s_b_end_y;

    sip_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .in_data  (pair),
        .out_valid(f_valid),
        .out_data (f_data)
    );

    sip_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (f_valid),
        .in_data  (f_data),
        .out_valid(d_valid),
        .out_data (d_data)
    );

    // a negative nonzero quotient is outside every box
    always_comb begin
        hit_next = !d_data.miss
                   && !(d_data.neg_x && d_data.qx != '0)
                   && !(d_data.neg_y && d_data.qy != '0)
                   && d_data.qx >= d_data.box.lo_x && d_data.qx <= d_data.box.hi_x
                   && d_data.qy >= d_data.box.lo_y && d_data.qy <= d_data.box.hi_y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_hit_reg <= hit_next;
            m_x_reg   <= hit_next ? d_data.qx : '0;
            m_y_reg   <= hit_next ? d_data.qy : '0;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_hit     = m_hit_reg;
    assign m_cross_x = m_x_reg;
    assign m_cross_y = m_y_reg;

endmodule

`default_nettype wire

// ----- sv/sip_checker.sv -----
// ----------------------------------------------------------------------------
// sip_checker
// Port-level checks for segment_intersection_point, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sip_checker (
    input wire logic            aclk,
    input wire logic            aresetn,
    input wire logic            s_ready,
    input wire logic            m_valid,
    input wire logic            m_ready,
    input wire logic            m_hit,
    input wire sip_pkg::coord_t m_cross_x,
    input wire sip_pkg::coord_t m_cross_y
);

    // the pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an empty output never blocks the input side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // a miss beat carries a zero point
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_cross_x == '0 && m_cross_y == '0)
        else $error("miss with nonzero point");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_cross_x)
        && $stable(m_cross_y))
        else $error("stalled result changed");

endmodule

bind segment_intersection_point sip_checker u_sip_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_hit    (m_hit),
    .m_cross_x(m_cross_x),
    .m_cross_y(m_cross_y)
);

`default_nettype wire

// ----- dv/segment_intersection_point_tb.sv -----
// ----------------------------------------------------------------------------
// segment_intersection_point_tb
// Drives segment pairs through the intersection pipeline and checks each
// result beat against an exact integer prediction of the crossing point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_intersection_point_tb;
    import sip_pkg::*;

    localparam int RANDOM_PAIRS = 1600;
    localparam int STALL_CYCLES = 300;
    localparam longint CYCLE_LIMIT = 400000;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic   hit;
        coord_t cx;
        coord_t cy;
    } crossing_t;

    typedef struct {
        seg_pair_t pair;
        bit        typed;
        crossing_t want;
    } stim_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    seg_pair_t s_pair = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    logic      m_hit;
    coord_t    m_cross_x;
    coord_t    m_cross_y;

    crossing_t expected_crossings[$];
    stim_row_t directed_rows[$];
    int        mismatches = 0;
    int        pairs_sent = 0;
    int        results_seen = 0;
    int        hits_seen = 0;
    bit        quiet_tail = 1'b0;
    bit        hold_off = 1'b0;
    bit        stall_done = 1'b0;
    longint    cycles = 0;

    always #5 aclk = ~aclk;

    segment_intersection_point dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_a_start_x (s_pair.ax0),
        .s_a_start_y (s_pair.ay0),
        .s_a_end_x   (s_pair.ax1),
        .s_a_end_y   (s_pair.ay1),
        .s_b_start_x (s_pair.bx0),
        .s_b_start_y (s_pair.by0),
        .s_b_end_x   (s_pair.bx1),
        .s_b_end_y   (s_pair.by1),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hit       (m_hit),
        .m_cross_x   (m_cross_x),
        .m_cross_y   (m_cross_y)
    );

    function automatic bit within_span(longint v, longint e0, longint e1);
        longint lo;
        longint hi;
        lo = (e0 < e1) ? e0 : e1;
        hi = (e0 < e1) ? e1 : e0;
        return v >= lo && v <= hi;
    endfunction

    // exact 64-bit math, sv division truncates toward zero
    function automatic crossing_t predict_crossing(seg_pair_t p);
        longint x1, y1, x2, y2, x3, y3, x4, y4;
        longint dxa, dya, dxb, dyb, det, ca, cb, px, py;
        crossing_t r;
        x1 = p.ax0; y1 = p.ay0; x2 = p.ax1; y2 = p.ay1;
        x3 = p.bx0; y3 = p.by0; x4 = p.bx1; y4 = p.by1;
        r = '0;
        dxa = x1 - x2; dya = y1 - y2;
        dxb = x3 - x4; dyb = y3 - y4;
        det = dxa * dyb - dya * dxb;
        if (det != 0) begin
            ca = x1 * y2 - y1 * x2;
            cb = x3 * y4 - y3 * x4;
            px = (ca * dxb - dxa * cb) / det;
            py = (ca * dyb - dya * cb) / det;
            if (within_span(px, x1, x2) && within_span(py, y1, y2) &&
                within_span(px, x3, x4) && within_span(py, y3, y4)) begin
                r.hit = 1'b1;
                r.cx = coord_t'(px);
                r.cy = coord_t'(py);
            end
        end
        return r;
    endfunction

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return coord_t'($urandom_range(0, 15));
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic seg_pair_t random_pair();
        seg_pair_t p;
        coord_t cx, cy;
        p.ax0 = rand_coord(); p.ay0 = rand_coord();
        p.ax1 = rand_coord(); p.ay1 = rand_coord();
        p.bx0 = rand_coord(); p.by0 = rand_coord();
        p.bx1 = rand_coord(); p.by1 = rand_coord();
        // most pairs are built around a shared point so that hits are common
        if ($urandom_range(0, 3) != 0) begin
            cx = coord_t'($urandom); cy = coord_t'($urandom);
            p.ax0 = cx - coord_t'($urandom_range(0, cx));
            p.ax1 = cx + coord_t'($urandom_range(0, 4095 - cx));
            p.ay0 = cy - coord_t'($urandom_range(0, cy));
            p.ay1 = cy + coord_t'($urandom_range(0, 4095 - cy));
            p.bx0 = cx - coord_t'($urandom_range(0, cx));
            p.bx1 = cx + coord_t'($urandom_range(0, 4095 - cx));
            p.by1 = cy - coord_t'($urandom_range(0, cy));
            p.by0 = cy + coord_t'($urandom_range(0, 4095 - cy));
        end
        return p;
    endfunction

    function automatic seg_pair_t mk(int a, int b, int c, int d,
                                     int e, int f, int g, int h);
        seg_pair_t p;
        p.ax0 = coord_t'(a); p.ay0 = coord_t'(b);
        p.ax1 = coord_t'(c); p.ay1 = coord_t'(d);
        p.bx0 = coord_t'(e); p.by0 = coord_t'(f);
        p.bx1 = coord_t'(g); p.by1 = coord_t'(h);
        return p;
    endfunction

    task automatic add_row(seg_pair_t p, bit typed, crossing_t w);
        stim_row_t row;
        row.pair = p;
        row.typed = typed;
        row.want = w;
        directed_rows.push_back(row);
    endtask

    task automatic send_pair(seg_pair_t p, crossing_t w);
        int gap;
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 5);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pair <= p;
        expected_crossings.push_back(w);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pairs_sent++;
    endtask

    task automatic build_directed();
        crossing_t none;
        none = '0;
        // all zero, degenerate
        add_row(mk(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, none);
        // all ones, degenerate
        add_row(mk(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095), 1'b1, none);
        // full diagonals cross at the center, truncated
        add_row(mk(0, 0, 4095, 4095, 0, 4095, 4095, 0), 1'b1, {1'b1, 12'd2047, 12'd2047});
        // parallel
        add_row(mk(0, 0, 100, 0, 0, 5, 100, 5), 1'b1, none);
        // collinear overlapping
        add_row(mk(0, 0, 10, 10, 5, 5, 20, 20), 1'b1, none);
        // plus shape at a known point
        add_row(mk(10, 20, 30, 20, 20, 10, 20, 30), 1'b1, {1'b1, 12'd20, 12'd20});
        // lines cross outside both boxes
        add_row(mk(0, 0, 10, 0, 100, 5, 100, 50), 1'b1, none);
        // touching at an endpoint
        add_row(mk(0, 0, 4095, 0, 4095, 0, 4095, 4095), 1'b1, {1'b1, 12'd4095, 12'd0});
        // non-integer crossings, rounding and edge of box
        add_row(mk(0, 0, 3, 1, 0, 1, 3, 0), 1'b0, none);
        add_row(mk(4095, 0, 0, 4095, 0, 0, 4095, 4094), 1'b0, none);
        add_row(mk(1, 0, 0, 4095, 0, 1, 4095, 0), 1'b0, none);
        add_row(mk(4095, 4095, 0, 1, 1, 0, 4094, 4095), 1'b0, none);
        add_row(mk(2730, 1365, 1365, 2730, 0, 0, 4095, 4095), 1'b0, none);
        add_row(mk(4095, 0, 0, 0, 0, 4095, 4095, 1), 1'b0, none);
        // single bit and alternating bit patterns on the inputs
        add_row(mk(2048, 1, 1, 2048, 1, 1, 2048, 2048), 1'b0, none);
        add_row(mk(1365, 2730, 2730, 1365, 2730, 2730, 1365, 1365), 1'b0, none);
    endtask

    // sender
    initial begin
        seg_pair_t p;
        crossing_t w;
        build_directed();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_rows[i]) begin
            w = directed_rows[i].typed ? directed_rows[i].want
                                       : predict_crossing(directed_rows[i].pair);
            send_pair(directed_rows[i].pair, w);
        end
        for (int i = 0; i < RANDOM_PAIRS; i++) begin
            if (i == RANDOM_PAIRS * 7 / 8) quiet_tail = 1'b1;
            p = random_pair();
            send_pair(p, predict_crossing(p));
        end
        s_valid <= 1'b0;
    end

    // long hold-off on the result side, sender keeps offering
    initial begin
        wait (pairs_sent == 400);
        hold_off = 1'b1;
        repeat (STALL_CYCLES) @(posedge aclk);
        hold_off = 1'b0;
        stall_done = 1'b1;
    end

    // receiver ready
    initial begin
        int gap;
        @(posedge aclk);
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                @(posedge aclk);
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 5);
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // result check
    always @(posedge aclk) begin
        crossing_t got;
        crossing_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_hit, m_cross_x, m_cross_y};
            results_seen++;
            if (m_hit) hits_seen++;
            if (expected_crossings.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result beat: hit %0b x %0d y %0d",
                             got.hit, got.cx, got.cy);
            end else begin
                want = expected_crossings.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("beat %0d mismatch: exp hit %0b x %0d y %0d, got hit %0b x %0d y %0d",
                                 results_seen, want.hit, want.cx, want.cy,
                                 got.hit, got.cx, got.cy);
                end
            end
        end
    end

    // end of run
    initial begin
        wait (pairs_sent == directed_rows.size() + RANDOM_PAIRS && stall_done);
        while (expected_crossings.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        mismatches += expected_crossings.size();
        $display("%0d segment pairs sent, %0d results checked, %0d hits",
                 pairs_sent, results_seen, hits_seen);
        $display("covered parallel, collinear, degenerate, box edges and a long output stall");
        if (mismatches == 0)
            $display("segment_intersection_point test passed");
        else
            $display("segment_intersection_point test failed");
        $finish;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("segment_intersection_point test failed");
            $finish;
        end
    end

endmodule
